/* src/assert_macros.svh */
// Assertion macros used by the top level of the list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* src/ovl_pkg.sv */
// Types and codes of the ordered value list engine.
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

  // command codes; five to seven are unused
  localparam logic [2:0] CMD_APPEND   = 3'd0;
  localparam logic [2:0] CMD_SEARCH   = 3'd1;
  localparam logic [2:0] CMD_DELETE   = 3'd2;
  localparam logic [2:0] CMD_DUMP_FWD = 3'd3;
  localparam logic [2:0] CMD_DUMP_REV = 3'd4;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // input item
  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    status_e            status;
    logic signed [31:0] item_value;
    logic               last;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;      // latch command and value
    logic    append;    // write value at tail, one result
    logic    reply;     // one immediate result with reply_st
    status_e reply_st;
    logic    scan_init; // clear the scan counters
    logic    scan_en;   // walk the stored entries
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_done;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/ovl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ovl_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/ovl_ctrl.sv */
// Controller state machine: decodes commands and sequences entry scans.
`timescale 1ns / 1ps
`default_nettype none

module ovl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [2:0]        command_i,
  input  wire ovl_pkg::dp_stat_t stat_i,
  output ovl_pkg::dp_cmd_t       cmd_o,
  output logic                   busy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  // next state and datapath commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (command_i)
            ovl_pkg::CMD_APPEND: begin
              if (stat_i.full) begin
                cmd_o.reply    = 1'b1;
                cmd_o.reply_st = ovl_pkg::ST_FULL;
              end else begin
                cmd_o.append = 1'b1;
              end
            end
            ovl_pkg::CMD_SEARCH, ovl_pkg::CMD_DELETE,
            ovl_pkg::CMD_DUMP_FWD, ovl_pkg::CMD_DUMP_REV: begin
              if (stat_i.empty) begin
                cmd_o.reply    = 1'b1;
                cmd_o.reply_st = ovl_pkg::ST_EMPTY;
              end else begin
                cmd_o.scan_init = 1'b1;
                state_d         = S_SCAN;
              end
            end
            default: begin
              // unused code: dropped without a result
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* src/ovl_dp.sv */
// Datapath: entry store, count, scan pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

module ovl_dp #(
  parameter int Depth = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ovl_pkg::dp_cmd_t  cmd_i,
  input  wire ovl_pkg::in_item_t in_i,
  output ovl_pkg::dp_stat_t      stat_o,
  output logic                   res_valid_o,
  output ovl_pkg::result_t       res_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [CW-1:0] One  = CW'(1);
  localparam logic [CW-1:0] Full = CW'(Depth);

  logic [CW-1:0]    count_q, count_d;
  logic [2:0]       op_q;
  logic [31:0]      value_q;
  logic [CW-1:0]    rd_k_q;
  logic [CW-1:0]    cmp_k_q;
  logic             cmp_vld_q;
  logic             found_q;
  logic             res_valid_q, res_valid_d;
  ovl_pkg::result_t res_q, res_d;

  logic             is_dump, is_rev, is_del;
  logic             rd_en, we, match, hit, last_cmp;
  logic [CW-1:0]    rev_k, km1, last_k;
  logic [AW-1:0]    raddr, waddr;
  logic [31:0]      wdata, rdata;

  assign is_dump = (op_q == ovl_pkg::CMD_DUMP_FWD) || (op_q == ovl_pkg::CMD_DUMP_REV);
  assign is_rev  = (op_q == ovl_pkg::CMD_DUMP_REV);
  assign is_del  = (op_q == ovl_pkg::CMD_DELETE);

  // read issue: one entry per cycle, head to tail or tail to head
  assign last_k = count_q - One;
  assign rev_k  = last_k - rd_k_q;
  assign rd_en  = cmd_i.scan_en && (rd_k_q < count_q);
  assign raddr  = is_rev ? rev_k[AW-1:0] : rd_k_q[AW-1:0];

  // compare stage on the registered read data
  assign match    = (rdata == value_q);
  assign hit      = found_q || match;
  assign last_cmp = cmp_vld_q && (cmp_k_q == last_k);

  // write: tail append, or close the gap behind a deleted entry
  assign km1   = cmp_k_q - One;
  assign we    = cmd_i.append || (cmp_vld_q && found_q && is_del);
  assign waddr = cmd_i.append ? count_q[AW-1:0] : km1[AW-1:0];
  assign wdata = cmd_i.append ? in_i.value : rdata;

  ovl_ram #(
    .Width(32),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // count and result selection
  always_comb begin
    count_d     = count_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (cmd_i.append) begin
      count_d          = count_q + One;
      res_valid_d      = 1'b1;
      res_d.status     = ovl_pkg::ST_DONE;
      res_d.item_value = in_i.value;
      res_d.last       = 1'b1;
    end else if (cmd_i.reply) begin
      res_valid_d      = 1'b1;
      res_d.status     = cmd_i.reply_st;
      res_d.item_value = in_i.value;
      res_d.last       = 1'b1;
    end else if (cmp_vld_q) begin
      if (is_dump) begin
        res_valid_d      = 1'b1;
        res_d.status     = ovl_pkg::ST_DONE;
        res_d.item_value = rdata;
        res_d.last       = last_cmp;
      end else if (last_cmp) begin
        res_valid_d      = 1'b1;
        res_d.status     = hit ? ovl_pkg::ST_DONE : ovl_pkg::ST_MISSING;
        res_d.item_value = value_q;
        res_d.last       = 1'b1;
        if (is_del && hit) begin
          count_d = last_k;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cmp_vld_q   <= rd_en;
      res_valid_q <= res_valid_d;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.load) begin
      op_q    <= in_i.command;
      value_q <= in_i.value;
    end
    if (cmd_i.scan_init) begin
      rd_k_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_k_q <= rd_k_q + One;
      end
      if (cmp_vld_q && match) begin
        found_q <= 1'b1;
      end
    end
    cmp_k_q <= rd_k_q;
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == Full);
  assign stat_o.scan_done = last_cmp;
  assign res_valid_o      = res_valid_q;
  assign res_o            = res_q;

endmodule

`default_nettype wire

/* src/ordered_value_list_engine.sv */
// Top level of the ordered value list engine.
//
//   channel   signals                       handshake
//   command   start, busy, in_i             taken when start high, busy low
//   result    res_valid_o, res_o            one-cycle strobe, never stalled
//
// Append, and any command answered at once (full, empty), gives its result
// in the cycle after it is taken; busy stays low.
// Search, delete and dumps walk all stored entries through the RAM read
// port, one entry per cycle, while busy is high; the last result shows
// in the first cycle with busy low again. Unused codes are taken and dropped.
// Reset clears the entry count; the entry store itself is not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ordered_value_list_engine #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ovl_pkg::in_item_t in_i,
  output logic                   res_valid_o,
  output ovl_pkg::result_t       res_o
);

  ovl_pkg::dp_cmd_t  dp_cmd;
  ovl_pkg::dp_stat_t dp_stat;

  ovl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .command_i(in_i.command),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd),
    .busy     (busy)
  );

  ovl_dp #(
    .Depth(DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_i       (in_i),
    .stat_o     (dp_stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // an accepted append is answered in the next cycle with a last result
  `ASSERT_NEXT(a_append_reply, clk_i, rst_ni, start && !busy && (in_i.command == ovl_pkg::CMD_APPEND), res_valid_o && res_o.last)

  // a scan only finishes while the controller is busy
  `ASSERT_IMPLY(a_scan_busy, clk_i, rst_ni, dp_stat.scan_done, busy)

  // a non-final dump result means the walk is still going
  `ASSERT_IMPLY(a_dump_busy, clk_i, rst_ni, res_valid_o && !res_o.last, busy && (res_o.status == ovl_pkg::ST_DONE))

  // the list can never be full and empty at once
  `ASSERT_ALWAYS(a_full_empty, clk_i, rst_ni, !(dp_stat.full && dp_stat.empty))

endmodule

`default_nettype wire
